// ===== sv/x86io_pkg.sv =====
// Shared types, codes and opcode constants for the x86 I/O instruction decoder.
package x86io_pkg;

    // Prefix bound default
    localparam int unsigned MaxPrefixesDefault = 14;

    // Operand size codes held in prefix state
    localparam logic [1:0] OW_16 = 2'd1;
    localparam logic [1:0] OW_32 = 2'd2;
    localparam logic [1:0] OW_64 = 2'd3;

    // Address size codes held in prefix state
    localparam logic [1:0] AW_32 = 2'd2;
    localparam logic [1:0] AW_64 = 2'd3;

    // Result data width codes
    localparam logic [1:0] DW_8  = 2'd0;
    localparam logic [1:0] DW_16 = 2'd1;
    localparam logic [1:0] DW_32 = 2'd2;

    // Result address width codes
    localparam logic [1:0] RA_32 = 2'd1;
    localparam logic [1:0] RA_64 = 2'd2;

    // Result segment codes
    localparam logic [1:0] SEG_NONE = 2'd0;
    localparam logic [1:0] SEG_ES   = 2'd1;
    localparam logic [1:0] SEG_DS   = 2'd2;

    // Prefix and opcode bytes
    localparam logic [7:0] PFX_ES    = 8'h26;
    localparam logic [7:0] PFX_CS    = 8'h2E;
    localparam logic [7:0] PFX_SS    = 8'h36;
    localparam logic [7:0] PFX_DS    = 8'h3E;
    localparam logic [7:0] PFX_FS    = 8'h64;
    localparam logic [7:0] PFX_GS    = 8'h65;
    localparam logic [7:0] PFX_OPSZ  = 8'h66;
    localparam logic [7:0] PFX_ADSZ  = 8'h67;
    localparam logic [7:0] PFX_LOCK  = 8'hF0;
    localparam logic [7:0] PFX_REPNZ = 8'hF2;
    localparam logic [7:0] PFX_REPZ  = 8'hF3;
    localparam logic [7:0] OP_TWO_BYTE = 8'h0F;

    localparam logic [7:0] OP_INSB   = 8'h6C;
    localparam logic [7:0] OP_INSD   = 8'h6D;
    localparam logic [7:0] OP_OUTSB  = 8'h6E;
    localparam logic [7:0] OP_OUTSD  = 8'h6F;
    localparam logic [7:0] OP_IN_IB  = 8'hE4;
    localparam logic [7:0] OP_IN_ID  = 8'hE5;
    localparam logic [7:0] OP_OUT_IB = 8'hE6;
    localparam logic [7:0] OP_OUT_ID = 8'hE7;
    localparam logic [7:0] OP_IN_DB  = 8'hEC;
    localparam logic [7:0] OP_IN_DD  = 8'hED;
    localparam logic [7:0] OP_OUT_DB = 8'hEE;
    localparam logic [7:0] OP_OUT_DD = 8'hEF;

    // One input transfer
    typedef struct packed {
        logic [7:0]  instr_byte;
        logic        start_req;
        logic [15:0] dx_port;
    } t_io_byte;

    // One result transfer
    typedef struct packed {
        logic        supported;
        logic        is_input;
        logic        is_string;
        logic        has_rep;
        logic [1:0]  data_width;
        logic [1:0]  addr_width;
        logic [1:0]  segment_sel;
        logic [15:0] port_number;
        logic [4:0]  length;
    } t_io_result;

endpackage

// ===== sv/x86_io_instruction_decoder.sv =====
// x86 64-bit-mode I/O instruction decoder: prefix tracking and IN/OUT/INS/OUTS classification.
// The result is registered: it appears on the output register in the cycle after the byte that ends
// the instruction is transferred in.
// Throughput: one byte per cycle; the input stalls only while a held result is not taken.
// Reset (synchronous, active low): prefix state returns to its empty values and the
// output register is emptied.
module x86_io_instruction_decoder
    import x86io_pkg::*;
#(
    parameter int unsigned MAX_PREFIXES = MaxPrefixesDefault
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_io_byte   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_io_result o_out_data
);

    localparam logic [3:0] PfxLimit = 4'(MAX_PREFIXES);

    // Prefix state
    logic [3:0] r_prefix_count, n_prefix_count;
    logic [7:0] r_rex_value,    n_rex_value;
    logic [1:0] r_operand_w,    n_operand_w;
    logic [1:0] r_address_w,    n_address_w;
    logic       r_rep_seen,     n_rep_seen;
    logic       r_await_imm,    n_await_imm;
    logic [7:0] r_pending_op,   n_pending_op;

    // Output register
    logic       r_out_valid;
    t_io_result r_out_data;

    logic       in_xfer;
    logic       emit;
    t_io_result res;

    // Effective state after an optional start
    logic [3:0] e_cnt;
    logic [7:0] e_rex;
    logic [1:0] e_ow;
    logic [1:0] e_aw;
    logic       e_rep;
    logic       e_await;
    logic [7:0] b;

    function automatic logic f_is_prefix(input logic [7:0] v);
        logic hit;
        begin
            case (v) inside
                [8'h40:8'h4F], PFX_ES, PFX_CS, PFX_SS, PFX_DS, PFX_FS, PFX_GS,
                PFX_OPSZ, PFX_ADSZ, PFX_LOCK, PFX_REPNZ, PFX_REPZ: hit = 1'b1;
                default: hit = 1'b0;
            endcase
            return hit;
        end
    endfunction

    function automatic t_io_result f_io(
        input logic [7:0]  op,
        input logic [15:0] port,
        input logic [4:0]  len,
        input logic        rep,
        input logic [1:0]  ow,
        input logic [1:0]  aw
    );
        t_io_result r;
        logic       str;
        begin
            str           = (op[7:4] == 4'h6);
            r.supported   = 1'b1;
            r.is_input    = ~op[1];
            r.is_string   = str;
            r.has_rep     = rep;
            r.data_width  = !op[0] ? DW_8 : ((ow == OW_16) ? DW_16 : DW_32);
            r.addr_width  = (aw == AW_32) ? RA_32 : RA_64;
            r.segment_sel = !str ? SEG_NONE : (!op[1] ? SEG_ES : SEG_DS);
            r.port_number = port;
            r.length      = len;
            return r;
        end
    endfunction

    function automatic t_io_result f_unsup(input logic [4:0] len);
        t_io_result r;
        begin
            r        = '0;
            r.length = len;
            return r;
        end
    endfunction

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_xfer     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign b           = i_in_data.instr_byte;

    // Start clears prefix state before the byte is decoded
    always_comb begin
        if (i_in_data.start_req) begin
            e_cnt   = '0;
            e_rex   = '0;
            e_ow    = OW_32;
            e_aw    = AW_64;
            e_rep   = 1'b0;
            e_await = 1'b0;
        end else begin
            e_cnt   = r_prefix_count;
            e_rex   = r_rex_value;
            e_ow    = r_operand_w;
            e_aw    = r_address_w;
            e_rep   = r_rep_seen;
            e_await = r_await_imm;
        end
    end

    // Byte decode against running prefix state
    always_comb begin
        n_prefix_count = '0;
        n_rex_value    = '0;
        n_operand_w    = OW_32;
        n_address_w    = AW_64;
        n_rep_seen     = 1'b0;
        n_await_imm    = 1'b0;
        n_pending_op   = r_pending_op;
        emit           = 1'b1;
        res            = f_unsup({1'b0, e_cnt} + 5'd1);
        if (e_await) begin
            res = f_io(r_pending_op, {8'h00, b}, {1'b0, e_cnt} + 5'd2, e_rep, e_ow, e_aw);
        end else if (f_is_prefix(b)) begin
            if (e_cnt >= PfxLimit) begin
                res = f_unsup({1'b0, e_cnt} + 5'd1);
            end else begin
                emit           = 1'b0;
                n_prefix_count = e_cnt + 4'd1;
                n_rex_value    = e_rex;
                n_operand_w    = e_ow;
                n_address_w    = e_aw;
                n_rep_seen     = e_rep;
                if (b[7:4] == 4'h4) begin
                    n_rex_value = b;
                    if (b[3]) begin
                        n_operand_w = OW_64;
                    end
                end else if (b == PFX_OPSZ) begin
                    if (e_rex == 8'h00) begin
                        n_operand_w = OW_16;
                    end
                end else if (b == PFX_ADSZ) begin
                    n_address_w = AW_32;
                end else if (b == PFX_REPNZ || b == PFX_REPZ) begin
                    n_rep_seen = 1'b1;
                end
            end
        end else begin
            unique case (b) inside
                OP_INSB, OP_INSD, OP_OUTSB, OP_OUTSD,
                OP_IN_DB, OP_IN_DD, OP_OUT_DB, OP_OUT_DD: begin
                    res = f_io(b, i_in_data.dx_port, {1'b0, e_cnt} + 5'd1, e_rep, e_ow, e_aw);
                end
                OP_IN_IB, OP_IN_ID, OP_OUT_IB, OP_OUT_ID: begin
                    // Immediate port follows; keep prefix state
                    emit           = 1'b0;
                    n_pending_op   = b;
                    n_await_imm    = 1'b1;
                    n_prefix_count = e_cnt;
                    n_rex_value    = e_rex;
                    n_operand_w    = e_ow;
                    n_address_w    = e_aw;
                    n_rep_seen     = e_rep;
                end
                OP_TWO_BYTE: begin
                    res = f_unsup({1'b0, e_cnt} + 5'd2);
                end
                default: begin
                    res = f_unsup({1'b0, e_cnt} + 5'd1);
                end
            endcase
        end
    end

    // Prefix state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix_count <= '0;
            r_rex_value    <= '0;
            r_operand_w    <= OW_32;
            r_address_w    <= AW_64;
            r_rep_seen     <= 1'b0;
            r_await_imm    <= 1'b0;
            r_pending_op   <= '0;
        end else if (in_xfer) begin
            r_prefix_count <= n_prefix_count;
            r_rex_value    <= n_rex_value;
            r_operand_w    <= n_operand_w;
            r_address_w    <= n_address_w;
            r_rep_seen     <= n_rep_seen;
            r_await_imm    <= n_await_imm;
            r_pending_op   <= n_pending_op;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && emit) begin
            r_out_data <= res;
        end
    end

`ifndef SYNTH
    // Unsupported results carry only a length
    a_unsup_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_data.supported) |->
        (!r_out_data.is_input && !r_out_data.is_string && !r_out_data.has_rep &&
         r_out_data.data_width == DW_8 && r_out_data.segment_sel == SEG_NONE &&
         r_out_data.port_number == 16'h0000))
        else $error("unsupported result has nonzero fields");

    // String forms always name a segment
    a_string_seg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.is_string) |-> (r_out_data.segment_sel != SEG_NONE))
        else $error("string result without segment");

    // Awaiting an immediate only after an immediate IN/OUT opcode
    a_await_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_await_imm |-> (r_pending_op[7:2] == OP_IN_IB[7:2]))
        else $error("awaiting immediate with wrong opcode");

    // Prefix count never passes the bound
    a_pfx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prefix_count <= PfxLimit)
        else $error("prefix count beyond bound");

    // Input stalls only behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_out_valid && !i_out_ready))
        else $error("input stalled without a held result");
`endif

endmodule

// ===== tb/x86_io_instruction_decoder_tb.sv =====
// Self-checking testbench for the x86 I/O instruction decoder: byte driver, result monitor, decode predictor.
module x86_io_instruction_decoder_tb;
    import x86io_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MaxPfx      = MaxPrefixesDefault;
    localparam int unsigned HoldCycles  = 200;
    localparam int unsigned StallLimit  = 2000;
    localparam int unsigned PrintCap    = 40;

    // Clock and block inputs, all known from time zero
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    t_io_byte   i_in_data   = '0;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    t_io_result o_out_data;

    // Pending bytes and the decodes still owed by the block
    t_io_byte   byte_q[$];
    t_io_result decode_q[$];

    // Idle rates per side, in percent
    int unsigned snd_idle_pct = 0;
    int unsigned rcv_idle_pct = 0;

    // Long output stall requests and their bookkeeping
    int unsigned hold_reqs = 0;
    int unsigned hold_done = 0;
    int unsigned hold_left = 0;

    // Run statistics
    int unsigned err_count     = 0;
    int unsigned bytes_sent    = 0;
    int unsigned results_seen  = 0;
    int unsigned io_results    = 0;
    int unsigned rep_results   = 0;
    int unsigned idle_cycles   = 0;

    // Predictor copy of the decode state
    logic [3:0] pfx_cnt;
    logic [7:0] rex_byte;
    logic [1:0] opnd_sz;
    logic [1:0] adr_sz;
    logic       rep_flag;
    logic       imm_wait;
    logic [7:0] held_op;

    x86_io_instruction_decoder DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Decode predictor
    // ------------------------------------------------------------------

    function automatic void clear_prefix_state();
        pfx_cnt  = '0;
        rex_byte = '0;
        opnd_sz  = OW_32;
        adr_sz   = AW_64;
        rep_flag = 1'b0;
        imm_wait = 1'b0;
    endfunction

    function automatic bit is_prefix_byte(input logic [7:0] b);
        if (b[7:4] == 4'h4) return 1'b1;
        case (b) inside
            PFX_ES, PFX_CS, PFX_SS, PFX_DS, PFX_FS, PFX_GS,
            PFX_OPSZ, PFX_ADSZ, PFX_LOCK, PFX_REPNZ, PFX_REPZ: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // Builds the result of a recognized IN/OUT/INS/OUTS opcode
    function automatic t_io_result io_decode(input logic [7:0] op, input logic [15:0] port,
                                             input logic [4:0] len);
        t_io_result r;
        logic       str_op;
        logic       dir_in;
        str_op = (op[7:4] == 4'h6);
        dir_in = str_op ? (op <= OP_INSD) : !op[1];
        r.supported   = 1'b1;
        r.is_input    = dir_in;
        r.is_string   = str_op;
        r.has_rep     = rep_flag;
        r.data_width  = !op[0] ? DW_8 : ((opnd_sz == OW_16) ? DW_16 : DW_32);
        r.addr_width  = (adr_sz == AW_32) ? RA_32 : RA_64;
        r.segment_sel = str_op ? (dir_in ? SEG_ES : SEG_DS) : SEG_NONE;
        r.port_number = port;
        r.length      = len;
        return r;
    endfunction

    // Advances the predictor by one byte; returns 1 when an instruction ends
    function automatic bit decode_byte(input t_io_byte b, output t_io_result r);
        logic [7:0] op;
        logic [4:0] base_len;
        op = b.instr_byte;
        r  = '0;
        if (b.start_req) clear_prefix_state();
        base_len = {1'b0, pfx_cnt};

        // immediate port byte of IN/OUT imm8
        if (imm_wait) begin
            r = io_decode(held_op, {8'h00, op}, base_len + 5'd2);
            clear_prefix_state();
            return 1'b1;
        end

        if (is_prefix_byte(op)) begin
            // prefix run at its bound ends the instruction as unsupported
            if (pfx_cnt >= MaxPfx) begin
                r.length = base_len + 5'd1;
                clear_prefix_state();
                return 1'b1;
            end
            if (op[7:4] == 4'h4) begin
                rex_byte = op;
                if (op[3]) opnd_sz = OW_64;
            end else if (op == PFX_OPSZ) begin
                if (rex_byte == 8'h00) opnd_sz = OW_16;
            end else if (op == PFX_ADSZ) begin
                adr_sz = AW_32;
            end else if (op == PFX_REPNZ || op == PFX_REPZ) begin
                rep_flag = 1'b1;
            end
            pfx_cnt = pfx_cnt + 4'd1;
            return 1'b0;
        end

        if ((op >= OP_INSB && op <= OP_OUTSD) || (op >= OP_IN_DB && op <= OP_OUT_DD)) begin
            r = io_decode(op, b.dx_port, base_len + 5'd1);
            clear_prefix_state();
            return 1'b1;
        end
        if (op >= OP_IN_IB && op <= OP_OUT_ID) begin
            held_op  = op;
            imm_wait = 1'b1;
            return 1'b0;
        end

        // anything else is unsupported; two-byte escape counts its second byte
        r.length = base_len + ((op == OP_TWO_BYTE) ? 5'd2 : 5'd1);
        clear_prefix_state();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        err_count++;
        if (err_count <= PrintCap)
            $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h (result %0d)",
                     $realtime, what, got, want, results_seen);
    endtask

    task automatic check_field(input string what, input int unsigned got,
                               input int unsigned want);
        if (got != want) report_mismatch(what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic push_item(input logic [7:0] b, input logic s, input logic [15:0] dx);
        t_io_byte it;
        it.instr_byte = b;
        it.start_req  = s;
        it.dx_port    = dx;
        byte_q.push_back(it);
    endtask

    task automatic push_byte(input logic [7:0] b, input logic s);
        push_item(b, s, 16'($urandom_range(0, 65535)));
    endtask

    function automatic logic [7:0] io_opcode(input int unsigned idx);
        case (idx)
            0:       return OP_INSB;
            1:       return OP_INSD;
            2:       return OP_OUTSB;
            3:       return OP_OUTSD;
            4:       return OP_IN_IB;
            5:       return OP_IN_ID;
            6:       return OP_OUT_IB;
            7:       return OP_OUT_ID;
            8:       return OP_IN_DB;
            9:       return OP_IN_DD;
            10:      return OP_OUT_DB;
            default: return OP_OUT_DD;
        endcase
    endfunction

    function automatic logic [7:0] pick_prefix();
        case ($urandom_range(0, 14)) inside
            0:       return PFX_ES;
            1:       return PFX_CS;
            2:       return PFX_SS;
            3:       return PFX_DS;
            4:       return PFX_FS;
            5:       return PFX_GS;
            6, 7:    return PFX_OPSZ;
            8:       return PFX_ADSZ;
            9:       return PFX_LOCK;
            10:      return PFX_REPNZ;
            11:      return PFX_REPZ;
            default: return {4'h4, 4'($urandom_range(0, 15))};
        endcase
    endfunction

    // One instruction with random prefixes and content
    task automatic gen_instruction();
        int unsigned n_pfx;
        int unsigned sel;
        logic        first_start;
        logic [7:0]  op;
        first_start = 1'($urandom_range(0, 1));
        // occasional prefix runs long enough to reach the bound
        if ($urandom_range(0, 99) < 8) n_pfx = $urandom_range(MaxPfx - 1, MaxPfx + 2);
        else                            n_pfx = $urandom_range(0, 4);
        for (int i = 0; i < n_pfx; i++)
            push_byte(pick_prefix(), (i == 0) ? first_start : ($urandom_range(0, 49) == 0));

        sel = $urandom_range(0, 99);
        if (sel < 80)      op = io_opcode($urandom_range(0, 11));
        else if (sel < 88) op = OP_TWO_BYTE;
        else               op = 8'($urandom_range(0, 255));
        push_byte(op, (n_pfx == 0) ? first_start : 1'b0);

        // imm8 forms: usually the port byte, sometimes a restart that drops them
        if (op >= OP_IN_IB && op <= OP_OUT_ID) begin
            if ($urandom_range(0, 9) == 0) push_byte(io_opcode($urandom_range(0, 11)), 1'b1);
            else                           push_byte(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    task automatic fill_random(input int unsigned target);
        while (byte_q.size() < target) begin
            if ($urandom_range(0, 9) == 0) push_byte(8'($urandom_range(0, 255)),
                                                      1'($urandom_range(0, 1)));
            else                           gen_instruction();
        end
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (byte_q.size() != 0 || i_in_valid || decode_q.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Driver: offers queued bytes, predicts each accepted transfer
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drv
        t_io_result res;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (i_in_valid) begin
                bytes_sent++;
                if (decode_byte(i_in_data, res)) decode_q.push_back(res);
            end
            if (byte_q.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_data  <= byte_q.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compares each result transfer, drives ready and long holds
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : mon
        t_io_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (decode_q.size() == 0) begin
                    report_mismatch("unexpected result", 32'(o_out_data), 32'd0);
                end else begin
                    want = decode_q.pop_front();
                    if (want.supported) io_results++;
                    if (want.has_rep)   rep_results++;
                    check_field("supported",   32'(o_out_data.supported),   32'(want.supported));
                    check_field("is_input",    32'(o_out_data.is_input),    32'(want.is_input));
                    check_field("is_string",   32'(o_out_data.is_string),   32'(want.is_string));
                    check_field("has_rep",     32'(o_out_data.has_rep),     32'(want.has_rep));
                    check_field("data_width",  32'(o_out_data.data_width),
                                32'(want.data_width));
                    check_field("addr_width",  32'(o_out_data.addr_width),
                                32'(want.addr_width));
                    check_field("segment_sel", 32'(o_out_data.segment_sel),
                                32'(want.segment_sel));
                    check_field("port_number", 32'(o_out_data.port_number),
                                32'(want.port_number));
                    check_field("length",      32'(o_out_data.length),      32'(want.length));
                end
            end

            // ready: long hold on request, otherwise random idling
            if (hold_left != 0) begin
                i_out_ready <= 1'b0;
                hold_left   <= hold_left - 1;
            end else if (hold_done != hold_reqs) begin
                i_out_ready <= 1'b0;
                hold_left   <= HoldCycles;
                hold_done   <= hold_done + 1;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
            end
        end
    end

    // Watchdog: too long without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles <= 0;
        else                                                            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= StallLimit) begin
            $display("[%0t] watchdog: no transfer for %0d cycles", $realtime, idle_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence of phases
    // ------------------------------------------------------------------
    initial begin
        clear_prefix_state();
        held_op = '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: every opcode, prefix effects, field extremes, special cases
        @(negedge i_clk);
        snd_idle_pct = 34;
        rcv_idle_pct = 50;
        push_item(OP_INSB, 1'b1, 16'h0000);
        push_item(PFX_REPZ, 1'b1, 16'h1234);
        push_item(PFX_OPSZ, 1'b0, 16'h1234);
        push_item(OP_INSD, 1'b0, 16'hFFFF);
        push_item(PFX_ADSZ, 1'b1, 16'h0000);
        push_item(8'h48, 1'b0, 16'h0000);          // REX.W
        push_item(OP_OUTSD, 1'b0, 16'hA5A5);
        push_item(OP_OUTSB, 1'b0, 16'h5A5A);
        push_item(OP_IN_IB, 1'b1, 16'hFFFF);
        push_item(8'h00, 1'b0, 16'hFFFF);          // lowest immediate port
        push_item(PFX_OPSZ, 1'b0, 16'h0000);
        push_item(OP_IN_ID, 1'b0, 16'h0000);
        push_item(8'hFF, 1'b0, 16'h0000);          // highest immediate port
        push_item(8'h48, 1'b0, 16'h0001);
        push_item(PFX_OPSZ, 1'b0, 16'h0001);       // ignored after REX
        push_item(OP_OUT_ID, 1'b0, 16'h0001);
        push_item(8'h7F, 1'b0, 16'h0001);
        push_item(OP_OUT_IB, 1'b0, 16'h8000);
        push_item(OP_IN_DB, 1'b1, 16'h0001);       // restart drops the pending imm8 form
        push_item(OP_IN_DD, 1'b0, 16'h8000);
        push_item(PFX_REPNZ, 1'b0, 16'h7FFF);
        push_item(OP_OUT_DB, 1'b0, 16'hFFFF);
        push_item(OP_OUT_DD, 1'b0, 16'h0000);
        push_item(OP_TWO_BYTE, 1'b0, 16'h0000);    // unsupported two-byte escape
        push_item(PFX_LOCK, 1'b0, 16'h0000);
        push_item(8'h90, 1'b0, 16'hFFFF);          // unsupported opcode after prefix
        fill_random(325);
        wait_drained();

        // Swapped idle rates, opening with a long output hold while bytes keep coming
        snd_idle_pct = 50;
        rcv_idle_pct = 34;
        hold_reqs    = hold_reqs + 1;
        fill_random(310);
        wait_drained();

        // Full rate, no idling on either side
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        fill_random(315);
        wait_drained();

        repeat (5) @(posedge i_clk);

        $display("Covered %0d instruction bytes and %0d decoded instructions", bytes_sent,
                 results_seen);
        $display("(%0d I/O forms, %0d with REP, %0d unsupported) over three idle profiles",
                 io_results, rep_results, results_seen - io_results);
        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
